/* design/rmq_pkg.sv */
// Shared types, widths and the square root digit step for the matrix to quaternion converter.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    localparam int LANES     = 4;
    // One plus three elements needs two guard bits; the clamped radicand drops the sign.
    localparam int RAD_W     = DATA_W + 2;
    localparam int RADC_W    = RAD_W - 1;
    localparam int SQ_IN_W   = ((RADC_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int MAG_W     = ROOT_W - 1;

    localparam logic signed [RAD_W-1:0] ONE_RAD = RAD_W'(1 << FRAC_BITS);

    typedef logic [RADC_W-1:0] rad_t;
    typedef logic [MAG_W-1:0]  mag_t;

    // Packed so that m00 lands in the lowest bits of the stream word.
    typedef struct packed {
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m00;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] q_z;
        logic signed [DATA_W-1:0] q_y;
        logic signed [DATA_W-1:0] q_x;
        logic signed [DATA_W-1:0] q_scalar;
    } quat_t;

    // Sign information that travels beside the radicands.
    typedef struct packed {
        logic conv;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } side_t;

    typedef struct packed {
        logic [SQ_IN_W-1:0] rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } root_step_t;

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic root_step_t root_step(input root_step_t s);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        root_step_t       r;
        rem_sh = {s.rem, s.rad[SQ_IN_W-1 -: 2]};
        trial  = {2'b00, s.root, 2'b01};
        r.rad  = {s.rad[SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = REM_W'(rem_sh - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(rem_sh);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* design/rmq_front.sv */
// First stage: forms and clamps the four radicands and the vector sign flags.
`timescale 1ns / 1ps

module rmq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rmq_pkg::mat_t        mat,
    input  logic                 conv,
    output logic                 out_valid,
    output rmq_pkg::rad_t        rad [rmq_pkg::LANES],
    output rmq_pkg::side_t       side
);

    logic signed [rmq_pkg::RAD_W-1:0] e00, e11, e22;
    logic signed [rmq_pkg::RAD_W-1:0] r_full [rmq_pkg::LANES];
    rmq_pkg::rad_t                    r_clamp [rmq_pkg::LANES];
    rmq_pkg::side_t                   side_next;
    logic                             valid_reg;
    rmq_pkg::rad_t                    rad_reg [rmq_pkg::LANES];
    rmq_pkg::side_t                   side_reg;

    assign e00 = rmq_pkg::RAD_W'(mat.m00);
    assign e11 = rmq_pkg::RAD_W'(mat.m11);
    assign e22 = rmq_pkg::RAD_W'(mat.m22);

    always_comb
    begin
        r_full[0] =  e00 + e11 + e22 + rmq_pkg::ONE_RAD;
        r_full[1] =  e00 - e11 - e22 + rmq_pkg::ONE_RAD;
        r_full[2] = -e00 + e11 - e22 + rmq_pkg::ONE_RAD;
        r_full[3] = -e00 - e11 + e22 + rmq_pkg::ONE_RAD;
        for (int i = 0; i < rmq_pkg::LANES; i++)
        begin
            // A negative radicand gives a zero component.
            r_clamp[i] = r_full[i][rmq_pkg::RAD_W-1] ? '0 : r_full[i][rmq_pkg::RADC_W-1:0];
        end
        side_next.conv  = conv;
        side_next.neg_x = (mat.m21 < mat.m12);
        side_next.neg_y = (mat.m02 < mat.m20);
        side_next.neg_z = (mat.m10 < mat.m01);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= r_clamp;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

/* design/rmq_root_pipe.sv */
// Square root pipeline: one root digit per stage for all four lanes.
`timescale 1ns / 1ps

module rmq_root_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rmq_pkg::rad_t        rad [rmq_pkg::LANES],
    input  rmq_pkg::side_t       in_side,
    output logic                 out_valid,
    output rmq_pkg::mag_t        mag [rmq_pkg::LANES],
    output rmq_pkg::side_t       out_side
);

    // One stage per root bit.
    rmq_pkg::root_step_t        st_reg   [rmq_pkg::ROOT_W][rmq_pkg::LANES];
    rmq_pkg::side_t             side_reg [rmq_pkg::ROOT_W];
    logic [rmq_pkg::ROOT_W-1:0] valid_reg;
    rmq_pkg::root_step_t        seed     [rmq_pkg::LANES];

    always_comb
    begin
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            // Scale the radicand by the fraction bits so the root keeps the same format.
            seed[l].rad  = rmq_pkg::SQ_IN_W'(rad[l]) << rmq_pkg::FRAC_BITS;
            seed[l].rem  = '0;
            seed[l].root = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[rmq_pkg::ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int l = 0; l < rmq_pkg::LANES; l++)
            begin
                st_reg[0][l] <= rmq_pkg::root_step(seed[l]);
            end
            for (int k = 1; k < rmq_pkg::ROOT_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                for (int l = 0; l < rmq_pkg::LANES; l++)
                begin
                    st_reg[k][l] <= rmq_pkg::root_step(st_reg[k-1][l]);
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            // Halving the root drops its lowest bit.
            mag[l] = st_reg[rmq_pkg::ROOT_W-1][l].root[rmq_pkg::ROOT_W-1:1];
        end
    end

    assign out_valid = valid_reg[rmq_pkg::ROOT_W-1];
    assign out_side  = side_reg[rmq_pkg::ROOT_W-1];

endmodule

/* design/rmq_out.sv */
// Output stage: applies the signs and holds results in an output register with a skid entry.
`timescale 1ns / 1ps

module rmq_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rmq_pkg::mag_t        mag [rmq_pkg::LANES],
    input  rmq_pkg::side_t       side,
    output logic                 advance,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output rmq_pkg::quat_t       q
);

    logic                  flip;
    rmq_pkg::quat_t        q_next;
    rmq_pkg::quat_t        out_reg;
    rmq_pkg::quat_t        skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    function automatic logic signed [rmq_pkg::DATA_W-1:0] apply_sign(
        input rmq_pkg::mag_t m, input logic neg);
        logic signed [rmq_pkg::DATA_W-1:0] v;
        v = rmq_pkg::DATA_W'(m);
        return neg ? -v : v;
    endfunction

    always_comb
    begin
        // Under the minus convention the three vector signs are flipped; a zero scalar does not flip them.
        flip            = side.conv && (mag[0] != '0);
        q_next.q_scalar = rmq_pkg::DATA_W'(mag[0]);
        q_next.q_x      = apply_sign(mag[1], side.neg_x ^ flip);
        q_next.q_y      = apply_sign(mag[2], side.neg_y ^ flip);
        q_next.q_z      = apply_sign(mag[3], side.neg_z ^ flip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_reg <= q_next;
            end
            else
            begin
                skid_reg <= q_next;
            end
        end
    end

    assign advance       = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign q             = out_reg;

endmodule

/* design/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to unit quaternion converter.
//
// The input stream carries one 3x3 rotation matrix per word, nine signed Q1.14
// elements in row-major order with m00 in the lowest bits. The output stream
// carries one quaternion per word: scalar, x, y, z, each signed Q1.14, scalar
// lowest. The scalar part always leaves non-negative.
// A one-bit configuration channel selects the sign convention (0 for plus one,
// 1 for minus one); it is always ready and should be written while no word is
// in flight.
// Throughput is one matrix per clock while the receiver does not stall. A result
// passes through one stage that forms the radicands, sixteen stages that each
// resolve one bit of the square roots, and the output register, whose input
// applies the signs.
// Reset clears all valid flags and sets the convention to plus one.
// When the receiver stalls, the output register holds its word and one further
// word goes into a skid entry; s_axis_tready then drops for as long as that
// entry is full and the whole pipeline holds still.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 16 bits each
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // q_scalar, q_x, q_y, q_z from bit 0 up, 16 bits each
    output logic [63:0]   m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    logic                conv_reg;
    logic                advance;
    logic                front_valid;
    rmq_pkg::rad_t       front_rad [rmq_pkg::LANES];
    rmq_pkg::side_t      front_side;
    logic                root_valid;
    rmq_pkg::mag_t       root_mag [rmq_pkg::LANES];
    rmq_pkg::side_t      root_side;
    rmq_pkg::quat_t      q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            conv_reg <= cfg_data;
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = advance;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_axis_tvalid),
        .mat       (rmq_pkg::mat_t'(s_axis_tdata)),
        .conv      (conv_reg),
        .out_valid (front_valid),
        .rad       (front_rad),
        .side      (front_side)
    );

    rmq_root_pipe u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (front_valid),
        .rad       (front_rad),
        .in_side   (front_side),
        .out_valid (root_valid),
        .mag       (root_mag),
        .out_side  (root_side)
    );

    rmq_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (root_valid && advance),
        .mag           (root_mag),
        .side          (root_side),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .q             (q)
    );

    assign m_axis_tdata = q;

endmodule

/* design/rmq_checker.sv */
// Port-level checks for the matrix to quaternion converter, bound to the top level.
`timescale 1ns / 1ps

module rmq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [63:0]   m_axis_tdata
);

    // A word offered to the receiver stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The scalar part is never negative.
    a_scalar_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[15])
        else $error("negative scalar part");

    // The input side only stops after the output side has been stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input not ready without an output stall");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
